>>> rtl/core/tcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_pkg: shared types and constants of the text terminal
// Field widths, character and operation codes, and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package tcs_pkg;

  // Default screen geometry.
  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;

  // Fixed field widths of the item ports.
  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int RROW_W = 5;
  localparam int RCOL_W = 7;
  localparam int CELL_W = 16;
  localparam int COLOR_W = 8;

  // Character and color codes.
  localparam logic [CHAR_W-1:0]  CH_SPACE    = 8'h20;
  localparam logic [CHAR_W-1:0]  CH_NEWLINE  = 8'h0A;
  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h0F;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Register index on the configuration port (taken from paddr[2]).
  localparam logic REG_TEXT_COLOR = 1'b0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;     // latch the accepted input beat
    logic exec;        // perform the put or issue the cell read
    logic idx_clr;     // restart the sweep index
    logic scroll_step; // read one source cell and queue its copy
    logic fill_step;   // write one space cell at the sweep index
    logic fill_init;   // fill with the reset color
    logic post;        // load the output register
  } tcs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_clear;
    logic need_scroll;
    logic read_hit;
    logic copy_done;
    logic fill_done;
    logic slot_free;
  } tcs_status_t;

endpackage

>>> rtl/core/tcs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_ctrl: sequencing controller of the text terminal
// Accepts one item at a time and steps the datapath through the put, read,
// scroll, clear and post-reset fill sequences.
// ----------------------------------------------------------------------------
module tcs_ctrl
  import tcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  tcs_status_t status_i,
  output tcs_cmd_t    cmd_o
);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_EXEC   = 3'd2;
  localparam logic [2:0] ST_SCROLL = 3'd3;
  localparam logic [2:0] ST_FILL   = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0] state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_INIT: begin
        cmd_o.fill_step = 1'b1;
        cmd_o.fill_init = 1'b1;
        if (status_i.fill_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (status_i.op_clear) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_FILL;
        end else if (status_i.need_scroll) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_SCROLL;
        end else if (status_i.read_hit) begin
          state_d = ST_FINISH;
        end else if (status_i.slot_free) begin
          cmd_o.post = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_SCROLL: begin
        // The last queued copy is written in the cycle that leaves.
        if (status_i.copy_done) begin
          state_d = ST_FILL;
        end else begin
          cmd_o.scroll_step = 1'b1;
        end
      end
      ST_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (status_i.fill_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status_i.slot_free) begin
          cmd_o.post = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register; reset starts the screen fill sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

>>> rtl/core/tcs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_datapath: screen memory, cursor and result register
// Holds the latched item, the cursor, the sweep index, the screen memory
// with its registered read port, and the output beat register.
// ----------------------------------------------------------------------------
module tcs_datapath
  import tcs_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tcs_cmd_t           cmd_i,
  output tcs_status_t        status_o,
  input  logic [COLOR_W-1:0] text_color_i,
  input  logic [OP_W-1:0]    operation_i,
  input  logic [CHAR_W-1:0]  char_code_i,
  input  logic [RROW_W-1:0]  read_row_i,
  input  logic [RCOL_W-1:0]  read_col_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [CELL_W-1:0]  cell_data_o,
  output logic [RROW_W-1:0]  cursor_row_o,
  output logic [RCOL_W-1:0]  cursor_col_o,
  output logic               scrolled_o
);

  localparam int NCELLS = COLS * ROWS;
  localparam int COPY_N = COLS * (ROWS - 1);
  localparam int ADDR_W = $clog2(NCELLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);

  // Latched item.
  logic [OP_W-1:0]   op_q;
  logic [CHAR_W-1:0] ch_q;
  logic [RROW_W-1:0] rrow_q;
  logic [RCOL_W-1:0] rcol_q;

  // Cursor and scroll flag.
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic             scr_q, scr_d;

  // Sweep index and queued scroll copy.
  logic [ADDR_W-1:0] idx_q;
  logic              wr_pend_q;
  logic [ADDR_W-1:0] wr_addr_q;

  // Memory ports.
  logic [CELL_W-1:0] mem [NCELLS];
  logic [CELL_W-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata;

  // Output register.
  logic              out_valid_q;
  logic [CELL_W-1:0] cell_q;
  logic [RROW_W-1:0] orow_q;
  logic [RCOL_W-1:0] ocol_q;
  logic              oscr_q;

  logic is_put, is_nl, row_last, col_last, read_hit, slot_free;
  logic [ADDR_W-1:0] cur_addr, rd_addr;
  logic [COLOR_W-1:0] fill_color;

  // Decode of the latched item against the cursor.
  assign is_put   = (op_q == OP_PUT);
  assign is_nl    = (ch_q == CH_NEWLINE);
  assign row_last = (row_q == ROW_W'(ROWS - 1));
  assign col_last = (col_q == COL_W'(COLS - 1));
  assign read_hit = (op_q == OP_READ) && (32'(rrow_q) < 32'(ROWS))
                    && (32'(rcol_q) < 32'(COLS));
  assign slot_free = !out_valid_q || !out_stall_i;
  assign cur_addr = ADDR_W'(32'(row_q) * 32'(COLS) + 32'(col_q));
  assign rd_addr  = ADDR_W'(32'(rrow_q) * 32'(COLS) + 32'(rcol_q));
  assign fill_color = cmd_i.fill_init ? RESET_COLOR : text_color_i;

  assign status_o.op_clear    = (op_q == OP_CLEAR);
  assign status_o.need_scroll = is_put && (is_nl || col_last) && row_last;
  assign status_o.read_hit    = read_hit;
  assign status_o.copy_done   = (idx_q == ADDR_W'(COPY_N));
  assign status_o.fill_done   = (idx_q == ADDR_W'(NCELLS - 1));
  assign status_o.slot_free   = slot_free;

  // Cursor advance for a put beat.
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    scr_d = scr_q;
    if (cmd_i.load_in) begin
      scr_d = 1'b0;
    end
    if (cmd_i.exec && is_put) begin
      if (is_nl || col_last) begin
        col_d = '0;
        if (row_last) begin
          scr_d = 1'b1;
        end else begin
          row_d = row_q + ROW_W'(1);
        end
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  // Memory port selection; the sources never overlap in one cycle.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = {text_color_i, ch_q};
    mem_re    = 1'b0;
    mem_raddr = rd_addr;
    if (cmd_i.exec && is_put && !is_nl) begin
      mem_we = 1'b1;
    end else if (wr_pend_q) begin
      mem_we    = 1'b1;
      mem_waddr = wr_addr_q;
      mem_wdata = rdata_q;
    end else if (cmd_i.fill_step) begin
      mem_we    = 1'b1;
      mem_waddr = idx_q;
      mem_wdata = {fill_color, CH_SPACE};
    end
    if (cmd_i.exec && read_hit) begin
      mem_re = 1'b1;
    end else if (cmd_i.scroll_step) begin
      mem_re    = 1'b1;
      mem_raddr = ADDR_W'(32'(idx_q) + 32'(COLS));
    end
  end

  // Screen memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // Item latch and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q   <= operation_i;
      ch_q   <= char_code_i;
      rrow_q <= read_row_i;
      rcol_q <= read_col_i;
    end
    if (cmd_i.scroll_step) begin
      wr_addr_q <= idx_q;
    end
    if (cmd_i.post) begin
      cell_q <= read_hit ? rdata_q : '0;
      orow_q <= RROW_W'(row_d);
      ocol_q <= RCOL_W'(col_d);
      oscr_q <= scr_d;
    end
  end

  // Control state: cursor, index, queued copy, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      scr_q       <= 1'b0;
      idx_q       <= '0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      row_q     <= row_d;
      col_q     <= col_d;
      scr_q     <= scr_d;
      wr_pend_q <= cmd_i.scroll_step;
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.scroll_step || cmd_i.fill_step) begin
        idx_q <= idx_q + ADDR_W'(1);
      end
      if (cmd_i.post) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cell_data_o  = cell_q;
  assign cursor_row_o = orow_q;
  assign cursor_col_o = ocol_q;
  assign scrolled_o   = oscr_q;

endmodule

>>> rtl/core/text_terminal_cursor_scroll.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_cursor_scroll: text screen with cursor and scrolling
// A COLS by ROWS screen of color and character cells with a cursor. Puts,
// clears and cell reads arrive as input beats; each gives one result beat.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake               Payload
//  input    in         in_valid_i/in_stall_o   operation, char_code, read_row,
//                                              read_col
//  output   out        out_valid_o/out_stall_i cell_data, cursor_row,
//                                              cursor_col, scrolled
//  config   in         APB psel/penable/pready text_color at address 0
//
// One item at a time. A read goes through the registered memory read.
// A clear sweeps the memory one cell a cycle. A scroll copies
// COLS*(ROWS-1) cells one row up, each read through the registered read
// port and written back, then fills the bottom row.
// After reset a fill pass writes every cell with a white on black space;
// no item is taken meanwhile, configuration writes are.
// A stalled result beat holds in the output register while the next item
// is worked on; that item waits at its end for the register to free.
// ----------------------------------------------------------------------------
module text_terminal_cursor_scroll
  import tcs_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input item channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [OP_W-1:0]    operation_i,
  input  logic [CHAR_W-1:0]  char_code_i,
  input  logic [RROW_W-1:0]  read_row_i,
  input  logic [RCOL_W-1:0]  read_col_i,
  // Result channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CELL_W-1:0]  cell_data_o,
  output logic [RROW_W-1:0]  cursor_row_o,
  output logic [RCOL_W-1:0]  cursor_col_o,
  output logic               scrolled_o,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [COLOR_W-1:0] text_color_q;
  tcs_cmd_t           cmd;
  tcs_status_t        status;

  // Color register on the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= RESET_COLOR;
    end else if (psel && penable && pwrite && (paddr[2] == REG_TEXT_COLOR)) begin
      text_color_q <= pwdata[COLOR_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TEXT_COLOR) ? {24'b0, text_color_q} : 32'b0;

  tcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tcs_datapath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .text_color_i (text_color_q),
    .operation_i  (operation_i),
    .char_code_i  (char_code_i),
    .read_row_i   (read_row_i),
    .read_col_i   (read_col_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .cell_data_o  (cell_data_o),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o),
    .scrolled_o   (scrolled_o)
  );

  // An accepted item keeps the input side closed in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted twice in a row");

  // A scroll always leaves the cursor at column zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && scrolled_o |-> cursor_col_o == '0)
    else $error("scroll reported with cursor off column zero");

  // The reported cursor column stays on the screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(cursor_col_o) < 32'(COLS))
    else $error("cursor column beyond the screen");

  // A result is posted only on an empty or draining output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.post |-> status.slot_free)
    else $error("result posted over a stalled beat");

endmodule

>>> verif/tcs_screen_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_screen_checker: result predictor and comparator for the text terminal
// Watches the item, result and configuration channels. Keeps its own copy of
// the screen, the cursor and the text color, predicts the result of every
// accepted item, and compares each accepted result beat with the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module tcs_screen_checker
  import tcs_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Item channel as seen by the block.
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [OP_W-1:0]    operation_i,
  input  logic [CHAR_W-1:0]  char_code_i,
  input  logic [RROW_W-1:0]  read_row_i,
  input  logic [RCOL_W-1:0]  read_col_i,
  // Result channel.
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [CELL_W-1:0]  cell_data_i,
  input  logic [RROW_W-1:0]  cursor_row_i,
  input  logic [RCOL_W-1:0]  cursor_col_i,
  input  logic               scrolled_i,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  // Status for the testbench top.
  output int unsigned        pending_o,
  output int unsigned        mismatch_count_o
);

  typedef struct packed {
    logic [CELL_W-1:0] cell_data;
    logic [RROW_W-1:0] cursor_row;
    logic [RCOL_W-1:0] cursor_col;
    logic              scrolled;
  } term_result_t;

  // Shadow copy of the screen, cursor and color register.
  logic [CELL_W-1:0]  screen_q [COLS*ROWS];
  int unsigned        row_q;
  int unsigned        col_q;
  logic [COLOR_W-1:0] color_q;
  term_result_t       expected_q [$];

  function automatic logic [CELL_W-1:0] blank_cell(input logic [COLOR_W-1:0] color);
    return {color, CH_SPACE};
  endfunction

  function automatic void fill_screen(input logic [CELL_W-1:0] fill_val);
    for (int i = 0; i < COLS*ROWS; i++) screen_q[i] = fill_val;
  endfunction

  // Moves the cursor to the start of the next row. On the last row the
  // screen moves up one row and the bottom row gets colored spaces.
  function automatic logic advance_line();
    col_q = 0;
    if (row_q >= ROWS - 1) begin
      row_q = ROWS - 1;
      for (int i = 0; i < COLS*(ROWS-1); i++) screen_q[i] = screen_q[i+COLS];
      for (int i = 0; i < COLS; i++) screen_q[(ROWS-1)*COLS+i] = blank_cell(color_q);
      return 1'b1;
    end
    row_q++;
    return 1'b0;
  endfunction

  // Applies one item to the shadow screen and returns the result it gives.
  function automatic term_result_t screen_step(input logic [OP_W-1:0]   op,
                                               input logic [CHAR_W-1:0] ch,
                                               input logic [RROW_W-1:0] rr,
                                               input logic [RCOL_W-1:0] rc);
    term_result_t res;
    res = '0;
    case (op)
      OP_PUT: begin
        if (ch == CH_NEWLINE) begin
          res.scrolled = advance_line();
        end else begin
          if (row_q < ROWS && col_q < COLS) screen_q[row_q*COLS+col_q] = {color_q, ch};
          col_q++;
          if (col_q >= COLS) res.scrolled = advance_line();
        end
      end
      OP_CLEAR: begin
        fill_screen(blank_cell(color_q));
      end
      OP_READ: begin
        if (rr < ROWS && rc < COLS) res.cell_data = screen_q[rr*COLS+rc];
      end
      default: begin
        // The unused code leaves everything as it is.
      end
    endcase
    res.cursor_row = row_q[RROW_W-1:0];
    res.cursor_col = col_q[RCOL_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatch_count_o++;
  endtask

  // Compare result beats first, then record the prediction for a new item.
  always @(posedge clk_i or negedge rst_ni) begin
    term_result_t want;
    if (!rst_ni) begin
      fill_screen(blank_cell(RESET_COLOR));
      row_q            = 0;
      col_q            = 0;
      color_q          = RESET_COLOR;
      expected_q.delete();
      pending_o        = 0;
      mismatch_count_o = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_TEXT_COLOR) begin
        color_q = pwdata[COLOR_W-1:0];
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result beat arrived with no item outstanding");
        end else begin
          want = expected_q.pop_front();
          if (cell_data_i !== want.cell_data)
            report_mismatch($sformatf("cell_data 0x%h, expected 0x%h",
                                      cell_data_i, want.cell_data));
          if (cursor_row_i !== want.cursor_row)
            report_mismatch($sformatf("cursor_row %0d, expected %0d",
                                      cursor_row_i, want.cursor_row));
          if (cursor_col_i !== want.cursor_col)
            report_mismatch($sformatf("cursor_col %0d, expected %0d",
                                      cursor_col_i, want.cursor_col));
          if (scrolled_i !== want.scrolled)
            report_mismatch($sformatf("scrolled %b, expected %b",
                                      scrolled_i, want.scrolled));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(screen_step(operation_i, char_code_i, read_row_i, read_col_i));
      end
      pending_o = expected_q.size();
    end
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top of the text terminal
// Drives puts, newlines, clears, cell reads and the unused operation code,
// changes the text color between phases over the configuration port, and
// idles both channels at random. A checker beside the block predicts and
// compares every result beat; the top gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import tcs_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int SCREEN_CELLS   = COLS_DEF * ROWS_DEF;
  localparam int WATCHDOG_LIMIT = 10 * (SCREEN_CELLS + 3);
  localparam int END_PAUSE      = SCREEN_CELLS + 16;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [OP_W-1:0]   operation_i = '0;
  logic [CHAR_W-1:0] char_code_i = '0;
  logic [RROW_W-1:0] read_row_i  = '0;
  logic [RCOL_W-1:0] read_col_i  = '0;

  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [CELL_W-1:0] cell_data_o;
  logic [RROW_W-1:0] cursor_row_o;
  logic [RCOL_W-1:0] cursor_col_o;
  logic              scrolled_o;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned pending;
  int unsigned mismatch_count;
  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned items_sent    = 0;
  int unsigned quiet_cycles  = 0;

  text_terminal_cursor_scroll i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .char_code_i  (char_code_i),
    .read_row_i   (read_row_i),
    .read_col_i   (read_col_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cell_data_o  (cell_data_o),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o),
    .scrolled_o   (scrolled_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  tcs_screen_checker i_screen_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .operation_i      (operation_i),
    .char_code_i      (char_code_i),
    .read_row_i       (read_row_i),
    .read_col_i       (read_col_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .cell_data_i      (cell_data_o),
    .cursor_row_i     (cursor_row_o),
    .cursor_col_i     (cursor_col_o),
    .scrolled_i       (scrolled_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .pending_o        (pending),
    .mismatch_count_o (mismatch_count)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Random back-pressure on the result channel.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < sink_idle_pct);
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Presents one item beat after a random gap and waits until it is taken.
  task automatic send_item(input logic [OP_W-1:0]   op,
                           input logic [CHAR_W-1:0] ch,
                           input logic [RROW_W-1:0] rr,
                           input logic [RCOL_W-1:0] rc);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    char_code_i <= ch;
    read_row_i  <= rr;
    read_col_i  <= rc;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // A put with random content on the fields that the put ignores.
  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_item(OP_PUT, ch, RROW_W'($urandom_range(31)), RCOL_W'($urandom_range(127)));
  endtask

  task automatic read_cell(input logic [RROW_W-1:0] rr, input logic [RCOL_W-1:0] rc);
    send_item(OP_READ, CHAR_W'($urandom), rr, rc);
  endtask

  // Holds the sender until every outstanding result has come back.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Setup and access cycle of one register write.
  task automatic write_text_color(input logic [COLOR_W-1:0] color);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_TEXT_COLOR, 2'b00};
    pwdata  <= 32'(color);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random traffic made of text runs, newline bursts, read bursts, noise
  // and clears. Halfway through, the sender drains and the color changes.
  task automatic run_phase(input int unsigned n_items);
    int unsigned start;
    int unsigned kind;
    int unsigned len;
    logic        mid_done;
    start    = items_sent;
    mid_done = 1'b0;
    while (items_sent - start < n_items) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        len = $urandom_range(90, 1);
        repeat (len) begin
          if ($urandom_range(15) == 0) put_char(CH_NEWLINE);
          else if ($urandom_range(4) == 0) put_char(CHAR_W'($urandom_range(255)));
          else put_char(CHAR_W'($urandom_range(126, 32)));
        end
      end else if (kind < 55) begin
        len = $urandom_range(20, 1);
        repeat (len) put_char(CH_NEWLINE);
      end else if (kind < 80) begin
        len = $urandom_range(12, 1);
        repeat (len) begin
          if ($urandom_range(7) == 0)
            read_cell(RROW_W'($urandom_range(31)), RCOL_W'($urandom_range(127)));
          else
            read_cell(RROW_W'($urandom_range(ROWS_DEF-1)),
                      RCOL_W'($urandom_range(COLS_DEF-1)));
        end
      end else if (kind < 97) begin
        len = $urandom_range(8, 1);
        repeat (len) begin
          send_item(OP_W'($urandom_range(3)), CHAR_W'($urandom_range(255)),
                    RROW_W'($urandom_range(31)), RCOL_W'($urandom_range(127)));
        end
      end else begin
        send_item(OP_CLEAR, CHAR_W'($urandom), RROW_W'($urandom), RCOL_W'($urandom));
      end
      if (!mid_done && items_sent - start >= n_items / 2) begin
        wait_for_results();
        write_text_color(COLOR_W'($urandom_range(255)));
        mid_done = 1'b1;
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    src_idle_pct  = 23;
    sink_idle_pct = 61;

    // Directed part with the reset color: reset contents, reads outside
    // the screen, extreme characters, a newline, the unused code, a clear.
    read_cell(RROW_W'(0), RCOL_W'(0));
    read_cell(RROW_W'(ROWS_DEF - 1), RCOL_W'(COLS_DEF - 1));
    read_cell(RROW_W'(ROWS_DEF), RCOL_W'(0));
    read_cell(RROW_W'(0), RCOL_W'(COLS_DEF));
    read_cell(5'h1F, 7'h7F);
    put_char(8'h41);
    put_char(8'h00);
    put_char(8'hFF);
    read_cell(RROW_W'(0), RCOL_W'(0));
    read_cell(RROW_W'(0), RCOL_W'(1));
    read_cell(RROW_W'(0), RCOL_W'(2));
    read_cell(RROW_W'(0), RCOL_W'(3));
    put_char(CH_NEWLINE);
    put_char(8'h7E);
    read_cell(RROW_W'(1), RCOL_W'(0));
    send_item(OP_UNUSED, 8'hFF, 5'h1F, 7'h7F);
    send_item(OP_UNUSED, 8'h00, 5'h00, 7'h00);
    send_item(OP_CLEAR, 8'h00, 5'h00, 7'h00);
    read_cell(RROW_W'(0), RCOL_W'(0));
    read_cell(RROW_W'(1), RCOL_W'(0));
    wait_for_results();

    write_text_color(8'h00);
    run_phase(370);
    wait_for_results();

    src_idle_pct  = 61;
    sink_idle_pct = 23;
    write_text_color(8'hFF);
    run_phase(370);
    wait_for_results();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    write_text_color(COLOR_W'($urandom_range(255)));
    run_phase(360);
    wait_for_results();

    // Give a stray extra result time to show up.
    repeat (END_PAUSE) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/tcs_pkg.sv
rtl/core/tcs_ctrl.sv
rtl/core/tcs_datapath.sv
rtl/core/text_terminal_cursor_scroll.sv
verif/tcs_screen_checker.sv
verif/tb.sv
